/* hw/rtl/two_replica_block_allocator_defines.svh */
// Assertion helpers shared by the allocator RTL.
`ifndef TWO_REPLICA_BLOCK_ALLOCATOR_DEFINES_SVH
`define TWO_REPLICA_BLOCK_ALLOCATOR_DEFINES_SVH

// Implication checked in the same cycle.
`define TRA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Implication checked in the next cycle.
`define TRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

/* hw/rtl/tra_pkg.sv */
// ----------------------------------------------------------------------------
// tra_pkg
// Types and codes shared by the two-replica block allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package tra_pkg;

    localparam int WORD_BITS = 32;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [7:0] CFG_BLOCKS_PER_NODE = 8'd0;
    localparam logic [7:0] CFG_ACTIVE_MASK     = 8'd1;

    localparam logic [2:0] MEMOP_NONE = 3'd0;
    localparam logic [2:0] MEMOP_RD_A = 3'd1;
    localparam logic [2:0] MEMOP_WR_A = 3'd2;
    localparam logic [2:0] MEMOP_RD_B = 3'd3;
    localparam logic [2:0] MEMOP_WR_B = 3'd4;
    localparam logic [2:0] MEMOP_RD_R = 3'd5;
    localparam logic [2:0] MEMOP_WR_R = 3'd6;

    localparam logic [1:0] FIN_NONE  = 2'd0;
    localparam logic [1:0] FIN_FULL  = 2'd1;
    localparam logic [1:0] FIN_ALLOC = 2'd2;
    localparam logic [1:0] FIN_REL   = 2'd3;

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       scan;
        logic [2:0] mem_op;
        logic [1:0] fin;
        logic       publish;
    } tra_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic have_two;
        logic out_free;
    } tra_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/tra_ctrl.sv */
// ----------------------------------------------------------------------------
// tra_ctrl
// Sequencer for clearing, scanning and committing bitmap updates.
// ----------------------------------------------------------------------------
`default_nettype none
module tra_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                func,
    output logic                     in_stall,
    input  wire tra_pkg::tra_stat_t  stat,
    output tra_pkg::tra_cmd_t        cmd
);
    import tra_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_RDA   = 4'd5;
    localparam logic [3:0] S_WRA   = 4'd6;
    localparam logic [3:0] S_RDB   = 4'd7;
    localparam logic [3:0] S_WRB   = 4'd8;
    localparam logic [3:0] S_RDR   = 4'd9;
    localparam logic [3:0] S_WRR   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mem_op = MEMOP_NONE;
        cmd.fin    = FIN_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = func ? S_RDR : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_CHECK;
            S_CHECK:
            begin
                if (stat.have_two)
                    state_next = S_RDA;
                else
                begin
                    cmd.fin    = FIN_FULL;
                    state_next = S_FIN;
                end
            end
            S_RDA:
            begin
                cmd.mem_op = MEMOP_RD_A;
                state_next = S_WRA;
            end
            S_WRA:
            begin
                cmd.mem_op = MEMOP_WR_A;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.mem_op = MEMOP_RD_B;
                state_next = S_WRB;
            end
            S_WRB:
            begin
                cmd.mem_op = MEMOP_WR_B;
                cmd.fin    = FIN_ALLOC;
                state_next = S_FIN;
            end
            S_RDR:
            begin
                cmd.mem_op = MEMOP_RD_R;
                state_next = S_WRR;
            end
            S_WRR:
            begin
                cmd.mem_op = MEMOP_WR_R;
                cmd.fin    = FIN_REL;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* hw/rtl/tra_datapath.sv */
// ----------------------------------------------------------------------------
// tra_datapath
// Bitmap memory, configuration, scan accumulators and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module tra_datapath
#(
    parameter int NODES  = 8,
    parameter int BLOCKS = 256
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tra_pkg::tra_cmd_t  cmd,
    output tra_pkg::tra_stat_t      stat,
    input  wire logic               cfg_valid,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire logic               func,
    input  wire logic [15:0]        part_index,
    input  wire logic [20:0]        block_bytes,
    input  wire logic [2:0]         release_node,
    input  wire logic [7:0]         release_offset,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [2:0]              first_node,
    output logic [7:0]              first_offset,
    output logic [2:0]              second_node,
    output logic [7:0]              second_offset,
    output logic [15:0]             part_number_out,
    output logic [20:0]             bytes_out
);
    import tra_pkg::*;

    localparam int WPN = (BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int NW  = NODES * WPN;
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int NB  = $clog2(NODES);
    localparam int WB  = (WPN > 1) ? $clog2(WPN) : 1;
    localparam int OB  = $clog2(BLOCKS);
    localparam int OFW = (OB > 5) ? OB : 5;
    localparam int FB  = $clog2(BLOCKS + 1);

    logic [31:0]    mem [NW];
    logic [31:0]    rd_data_reg;

    logic [8:0]     bpn_reg;
    logic [7:0]     mask_reg;
    logic [31:0]    lim32;
    logic [31:0]    mask32;

    logic [AW-1:0]  clr_addr_reg;
    logic [AW-1:0]  sc_addr_reg;
    logic [NB-1:0]  sc_node_reg;
    logic [WB-1:0]  sc_word_reg;
    logic           p_valid_reg;
    logic [NB-1:0]  p_node_reg;
    logic [WB-1:0]  p_word_reg;
    logic           p_lastw_reg;

    logic [FB-1:0]  acc_free_reg;
    logic           acc_found_reg;
    logic [OFW-1:0] acc_off_reg;

    logic           b1_valid_reg;
    logic [NB-1:0]  b1_node_reg;
    logic [FB-1:0]  b1_free_reg;
    logic [OFW-1:0] b1_off_reg;
    logic           b2_valid_reg;
    logic [NB-1:0]  b2_node_reg;
    logic [FB-1:0]  b2_free_reg;
    logic [OFW-1:0] b2_off_reg;

    logic [15:0]    part_reg;
    logic [20:0]    bytes_reg;
    logic [2:0]     rel_node_reg;
    logic [7:0]     rel_off_reg;
    logic [1:0]     stg_status_reg;
    logic [2:0]     stg_n1_reg;
    logic [7:0]     stg_o1_reg;
    logic [2:0]     stg_n2_reg;
    logic [7:0]     stg_o2_reg;
    logic           out_valid_reg;

    logic [31:0]    freebits;
    logic [5:0]     pop;
    logic [4:0]     first_j;
    logic           word_found;
    logic [FB-1:0]  tot_free;
    logic           tot_found;
    logic [OFW-1:0] tot_off;
    logic           node_act;

    logic [AW-1:0]  addr_a;
    logic [AW-1:0]  addr_b;
    logic [AW-1:0]  addr_r;
    logic           rel_ok;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [31:0]    mem_wd;
    logic [AW-1:0]  mem_ra;

    assign lim32  = (32'(bpn_reg) > BLOCKS) ? 32'(BLOCKS) : 32'(bpn_reg);
    assign mask32 = 32'(mask_reg);

    // Free bits of the word under scan that fall below the usable limit.
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
            freebits[j] = ~rd_data_reg[j] && (((32'(p_word_reg) << 5) | 32'(j)) < lim32);
        pop        = 6'($countones(freebits));
        word_found = |freebits;
        first_j    = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
            if (freebits[j])
                first_j = 5'(j);
    end

    always_comb
    begin
        logic [FB-1:0]  base_free;
        logic           base_found;
        base_free  = (p_word_reg == '0) ? '0 : acc_free_reg;
        base_found = (p_word_reg == '0) ? 1'b0 : acc_found_reg;
        tot_free   = base_free + FB'(pop);
        tot_found  = base_found || word_found;
        if (!base_found && word_found)
            tot_off = OFW'((32'(p_word_reg) << 5) | 32'(first_j));
        else
            tot_off = acc_off_reg;
        node_act = mask32[5'(p_node_reg)];
    end

    assign addr_a = AW'(32'(b1_node_reg) * WPN + (32'(b1_off_reg) >> 5));
    assign addr_b = AW'(32'(b2_node_reg) * WPN + (32'(b2_off_reg) >> 5));
    assign addr_r = AW'(32'(rel_node_reg) * WPN + (32'(rel_off_reg) >> 5));
    assign rel_ok = (32'(rel_node_reg) < NODES) && (32'(rel_off_reg) < lim32)
                    && rd_data_reg[rel_off_reg[4:0]];

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_addr_reg;
        mem_wd = '0;
        mem_ra = sc_addr_reg;
        if (cmd.clr)
            mem_we = 1'b1;
        case (cmd.mem_op)
            MEMOP_RD_A: mem_ra = addr_a;
            MEMOP_WR_A:
            begin
                mem_we = 1'b1;
                mem_wa = addr_a;
                mem_wd = rd_data_reg | (32'd1 << b1_off_reg[4:0]);
            end
            MEMOP_RD_B: mem_ra = addr_b;
            MEMOP_WR_B:
            begin
                mem_we = 1'b1;
                mem_wa = addr_b;
                mem_wd = rd_data_reg | (32'd1 << b2_off_reg[4:0]);
            end
            MEMOP_RD_R: mem_ra = addr_r;
            MEMOP_WR_R:
            begin
                mem_we = rel_ok;
                mem_wa = addr_r;
                mem_wd = rd_data_reg & ~(32'd1 << rel_off_reg[4:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    assign stat.clr_last  = (clr_addr_reg == AW'(NW - 1));
    assign stat.scan_last = (sc_addr_reg == AW'(NW - 1));
    assign stat.have_two  = b2_valid_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpn_reg       <= 9'd256;
            mask_reg      <= 8'd255;
            clr_addr_reg  <= '0;
            p_valid_reg   <= 1'b0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_BLOCKS_PER_NODE)
                bpn_reg <= cfg_data;
            else if (cfg_valid && cfg_index == CFG_ACTIVE_MASK)
                mask_reg <= cfg_data[7:0];

            if (cmd.clr)
                clr_addr_reg <= clr_addr_reg + 1'b1;

            p_valid_reg <= cmd.scan;

            if (cmd.load)
            begin
                b1_valid_reg <= 1'b0;
                b2_valid_reg <= 1'b0;
            end
            else if (p_valid_reg && p_lastw_reg && node_act && tot_free != '0)
            begin
                // Ascending scan with >= keeps ties on the higher index.
                if (!b1_valid_reg || tot_free >= b1_free_reg)
                begin
                    b2_valid_reg <= b1_valid_reg;
                    b1_valid_reg <= 1'b1;
                end
                else
                    b2_valid_reg <= 1'b1;
            end

            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sc_addr_reg  <= '0;
            sc_node_reg  <= '0;
            sc_word_reg  <= '0;
            part_reg     <= func ? 16'd0 : part_index;
            bytes_reg    <= func ? 21'd0 : block_bytes;
            rel_node_reg <= release_node;
            rel_off_reg  <= release_offset;
        end
        else if (cmd.scan)
        begin
            sc_addr_reg <= sc_addr_reg + 1'b1;
            if (sc_word_reg == WB'(WPN - 1))
            begin
                sc_word_reg <= '0;
                sc_node_reg <= sc_node_reg + 1'b1;
            end
            else
                sc_word_reg <= sc_word_reg + 1'b1;
        end
        p_node_reg  <= sc_node_reg;
        p_word_reg  <= sc_word_reg;
        p_lastw_reg <= (sc_word_reg == WB'(WPN - 1));

        if (p_valid_reg)
        begin
            acc_free_reg  <= tot_free;
            acc_found_reg <= tot_found;
            acc_off_reg   <= tot_off;
        end

        if (!cmd.load && p_valid_reg && p_lastw_reg && node_act && tot_free != '0)
        begin
            if (!b1_valid_reg || tot_free >= b1_free_reg)
            begin
                b2_node_reg <= b1_node_reg;
                b2_free_reg <= b1_free_reg;
                b2_off_reg  <= b1_off_reg;
                b1_node_reg <= p_node_reg;
                b1_free_reg <= tot_free;
                b1_off_reg  <= tot_off;
            end
            else if (!b2_valid_reg || tot_free >= b2_free_reg)
            begin
                b2_node_reg <= p_node_reg;
                b2_free_reg <= tot_free;
                b2_off_reg  <= tot_off;
            end
        end

        case (cmd.fin)
            FIN_FULL:
            begin
                stg_status_reg <= ST_FULL;
                stg_n1_reg     <= '0;
                stg_o1_reg     <= '0;
                stg_n2_reg     <= '0;
                stg_o2_reg     <= '0;
            end
            FIN_ALLOC:
            begin
                stg_status_reg <= ST_DONE;
                stg_n1_reg     <= 3'(b1_node_reg);
                stg_o1_reg     <= 8'(b1_off_reg);
                stg_n2_reg     <= 3'(b2_node_reg);
                stg_o2_reg     <= 8'(b2_off_reg);
            end
            FIN_REL:
            begin
                stg_status_reg <= rel_ok ? ST_DONE : ST_BAD;
                stg_n1_reg     <= '0;
                stg_o1_reg     <= '0;
                stg_n2_reg     <= '0;
                stg_o2_reg     <= '0;
            end
            default: ;
        endcase

        if (cmd.publish)
        begin
            status          <= stg_status_reg;
            first_node      <= stg_n1_reg;
            first_offset    <= stg_o1_reg;
            second_node     <= stg_n2_reg;
            second_offset   <= stg_o2_reg;
            part_number_out <= part_reg;
            bytes_out       <= bytes_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* hw/rtl/two_replica_block_allocator.sv */
// Allocate: a scan reads one 32-bit word per cycle over NODES*ceil(BLOCKS/32) words,
// then both picks are read and written back; a full report skips those two updates.
// Release: read, check and write back, result, idle.
// One transaction at a time; the result goes valid as the input stall drops.
// After reset the bitmap memory is cleared word by word with input stalled;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// two_replica_block_allocator
// Places two copies of a block on the two least loaded active nodes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_replica_block_allocator_defines.svh"
module two_replica_block_allocator
#(
    parameter int NODES  = 8,
    parameter int BLOCKS = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [15:0] part_index,
    input  wire logic [20:0] block_bytes,
    input  wire logic [2:0]  release_node,
    input  wire logic [7:0]  release_offset,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [2:0]       first_node,
    output logic [7:0]       first_offset,
    output logic [2:0]       second_node,
    output logic [7:0]       second_offset,
    output logic [15:0]      part_number_out,
    output logic [20:0]      bytes_out
);
    import tra_pkg::*;

    tra_cmd_t  cmd;
    tra_stat_t stat;

    assign cfg_ready = 1'b1;

    tra_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tra_datapath #(.NODES(NODES), .BLOCKS(BLOCKS)) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .part_index      (part_index),
        .block_bytes     (block_bytes),
        .release_node    (release_node),
        .release_offset  (release_offset),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .first_node      (first_node),
        .first_offset    (first_offset),
        .second_node     (second_node),
        .second_offset   (second_offset),
        .part_number_out (part_number_out),
        .bytes_out       (bytes_out)
    );

    // An accepted transaction keeps the input side stalled while it runs.
    `TRA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // A new result is only published into a free output register.
    `TRA_ASSERT_SAME(a_publish_free, clk, rst_n, cmd.publish, !out_valid || !out_stall)
    // A full report carries no placement.
    `TRA_ASSERT_SAME(a_full_no_place, clk, rst_n, out_valid && status == ST_FULL, first_node == 3'd0 && second_node == 3'd0)

endmodule
`default_nettype wire
